// ----- hdl/gecg_pkg.sv -----
// Shared types, constants and arithmetic helpers of the edge convolution gradient block.
package gecg_pkg;

  localparam int VADDR_MAX_W = 22;
  localparam int WADDR_MAX_W = 14;
  localparam int CNT_W = 7;
  localparam int NODE_CNT_W = 13;
  localparam int ACC_W = 48;
  localparam int Q_W = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] CFG_FEATURE_COUNT = 2'd0;
  localparam logic [1:0] CFG_FILTER_COUNT = 2'd1;
  localparam logic [1:0] CFG_NODE_COUNT = 2'd2;

  localparam logic [2:0] OP_LOAD_VERTEX = 3'd0;
  localparam logic [2:0] OP_LOAD_WEIGHT = 3'd1;
  localparam logic [2:0] OP_EDGE = 3'd2;
  localparam logic [2:0] OP_READ_WGRAD = 3'd3;
  localparam logic [2:0] OP_READ_VGRAD = 3'd4;
  localparam logic [2:0] OP_CLEAR = 3'd5;

  typedef struct packed {
    logic [2:0] opcode;
    logic [1:0] batch_index;
    logic [7:0] node_a;
    logic [7:0] node_b;
    logic [5:0] feature_index;
    logic [3:0] filter_index;
    logic signed [31:0] data_value;
    logic signed [31:0] upstream_gradient;
  } request_t;

  typedef struct packed {
    logic signed [47:0] result_value;
    logic status;
  } result_t;

  typedef struct packed {
    logic [CNT_W-1:0] nf;
    logic [CNT_W-1:0] nc;
    logic [NODE_CNT_W-1:0] nn;
  } limits_t;

  typedef enum logic [2:0] {
    CMD_LOAD_V,
    CMD_LOAD_W,
    CMD_EDGE,
    CMD_READ_W,
    CMD_READ_V,
    CMD_CLEAR,
    CMD_FLAG
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t kind;
    logic [VADDR_MAX_W-1:0] vaddr;
    logic [WADDR_MAX_W-1:0] waddr;
    logic [VADDR_MAX_W-1:0] sbase;
    logic [VADDR_MAX_W-1:0] rbase;
    logic signed [Q_W-1:0] data;
    logic signed [Q_W-1:0] grad;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_READ,
    ST_E_ADDR,
    ST_E_MUL,
    ST_E_ACC
  } state_t;

  typedef enum logic [2:0] {
    UPD_BIAS_W,
    UPD_BIAS_R,
    UPD_WS,
    UPD_WR,
    UPD_VS,
    UPD_VR
  } upd_t;

  // Saturating 48-bit add.
  function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
                                                      input logic signed [ACC_W-1:0] b);
    logic signed [ACC_W:0] s;
    logic signed [ACC_W-1:0] r;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (s[ACC_W] != s[ACC_W-1]) begin
      r = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      r = s[ACC_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- hdl/gecg_front.sv -----
// Front end: checks the ranges of a request and turns it into a command with store addresses.
module gecg_front import gecg_pkg::*; #(
  parameter int MAX_FEATURES = 16,
  parameter int MAX_FILTERS = 16,
  parameter int MAX_NODES = 256,
  parameter int MAX_BATCH = 4
) (
  input  request_t request,
  input  limits_t  lim,
  output cmd_t     cmd
);

  logic batch_ok;
  logic na_ok;
  logic nb_ok;
  logic vert_ok;
  logic w_ok;
  logic edge_ok;
  logic [VADDR_MAX_W-1:0] row_a;
  logic [VADDR_MAX_W-1:0] row_b;

  assign batch_ok = 5'(request.batch_index) < 5'(MAX_BATCH);
  assign na_ok = NODE_CNT_W'(request.node_a) < lim.nn;
  assign nb_ok = NODE_CNT_W'(request.node_b) < lim.nn;
  assign vert_ok = batch_ok && na_ok && (CNT_W'(request.feature_index) < lim.nf);
  assign w_ok = ((CNT_W+1)'(request.feature_index) <= {lim.nf, 1'b0}) &&
                (CNT_W'(request.filter_index) < lim.nc);
  assign edge_ok = batch_ok && na_ok && nb_ok;

  assign row_a = VADDR_MAX_W'(request.batch_index) * VADDR_MAX_W'(MAX_NODES) +
                 VADDR_MAX_W'(request.node_a);
  assign row_b = VADDR_MAX_W'(request.batch_index) * VADDR_MAX_W'(MAX_NODES) +
                 VADDR_MAX_W'(request.node_b);

  always_comb begin
    cmd.sbase = row_a * VADDR_MAX_W'(MAX_FEATURES);
    cmd.rbase = row_b * VADDR_MAX_W'(MAX_FEATURES);
    cmd.vaddr = cmd.sbase + VADDR_MAX_W'(request.feature_index);
    cmd.waddr = WADDR_MAX_W'(request.feature_index) * WADDR_MAX_W'(MAX_FILTERS) +
                WADDR_MAX_W'(request.filter_index);
    cmd.data = request.data_value;
    cmd.grad = request.upstream_gradient;
    unique case (request.opcode)
      OP_LOAD_VERTEX: cmd.kind = vert_ok ? CMD_LOAD_V : CMD_FLAG;
      OP_LOAD_WEIGHT: cmd.kind = w_ok ? CMD_LOAD_W : CMD_FLAG;
      OP_EDGE:        cmd.kind = edge_ok ? CMD_EDGE : CMD_FLAG;
      OP_READ_WGRAD:  cmd.kind = w_ok ? CMD_READ_W : CMD_FLAG;
      OP_READ_VGRAD:  cmd.kind = vert_ok ? CMD_READ_V : CMD_FLAG;
      OP_CLEAR:       cmd.kind = CMD_CLEAR;
      default:        cmd.kind = CMD_FLAG;
    endcase
  end

endmodule

// ----- hdl/gecg_fifo.sv -----
// Short command queue between the front end and the execution unit.
module gecg_fifo import gecg_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  input  logic pop,
  output cmd_t pop_data,
  output logic empty,
  output logic full
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t entries [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign empty = (count == '0);
  assign full = (count == CW'(QUEUE_DEPTH));
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ----- hdl/gecg_back.sv -----
// Execution unit: holds the four stores and runs loads, reads, clears and edge walks.
module gecg_back import gecg_pkg::*; #(
  parameter int MAX_FEATURES = 16,
  parameter int MAX_FILTERS = 16,
  parameter int MAX_NODES = 256,
  parameter int MAX_BATCH = 4
) (
  input  logic    clk,
  input  logic    rst,
  input  limits_t lim,
  input  logic    q_empty,
  input  cmd_t    head,
  output logic    pop,
  output logic    init_busy,
  output logic    done,
  output result_t result
);

  localparam int VDEPTH = MAX_BATCH * MAX_NODES * MAX_FEATURES;
  localparam int WDEPTH = (2 * MAX_FEATURES + 1) * MAX_FILTERS;
  localparam int CLR_DEPTH = (VDEPTH > WDEPTH) ? VDEPTH : WDEPTH;
  localparam int VAW = $clog2(VDEPTH);
  localparam int WAW = $clog2(WDEPTH);
  localparam int CAW = $clog2(CLR_DEPTH);

  logic [Q_W-1:0] vmem [VDEPTH];
  logic [Q_W-1:0] wmem [WDEPTH];
  logic [ACC_W-1:0] wgmem [WDEPTH];
  logic [ACC_W-1:0] vgmem [VDEPTH];

  state_t state;
  state_t state_next;
  cmd_t cur;
  upd_t step;
  logic [CNT_W-1:0] f_idx;
  logic [CNT_W-1:0] c_idx;
  logic signed [ACC_W-1:0] res_acc;
  logic signed [ACC_W-1:0] prod;
  logic [CAW-1:0] clr_addr;
  logic clr_reply;

  logic signed [Q_W-1:0] v_q;
  logic signed [Q_W-1:0] w_q;
  logic signed [ACC_W-1:0] wg_q;
  logic signed [ACC_W-1:0] vg_q;

  logic [WADDR_MAX_W-1:0] ws_addr;
  logic [WADDR_MAX_W-1:0] wr_addr;
  logic [WADDR_MAX_W-1:0] bias_addr;
  logic [VADDR_MAX_W-1:0] sv_addr;
  logic [VADDR_MAX_W-1:0] rv_addr;
  logic [WAW-1:0] w_raddr;
  logic [VAW-1:0] v_raddr;
  logic [WAW-1:0] wg_addr;
  logic [VAW-1:0] vg_addr;

  logic f_last;
  logic c_last;
  logic edge_last;
  logic clr_last;
  logic signed [Q_W-1:0] operand;
  logic signed [2*Q_W-1:0] full_prod;
  logic signed [ACC_W-1:0] wg_sum;
  logic signed [ACC_W-1:0] vg_sum;
  logic signed [ACC_W-1:0] res_sum;

  logic v_we;
  logic w_we;
  logic wg_we;
  logic vg_we;
  logic signed [ACC_W-1:0] wg_wdata;
  logic signed [ACC_W-1:0] vg_wdata;
  logic emit;
  result_t emit_res;

  // Store addresses for the current filter and feature of an edge walk.
  assign ws_addr = WADDR_MAX_W'(f_idx) * WADDR_MAX_W'(MAX_FILTERS) + WADDR_MAX_W'(c_idx);
  assign wr_addr = (WADDR_MAX_W'(lim.nf) + WADDR_MAX_W'(f_idx)) * WADDR_MAX_W'(MAX_FILTERS) +
                   WADDR_MAX_W'(c_idx);
  assign bias_addr = WADDR_MAX_W'({lim.nf, 1'b0}) * WADDR_MAX_W'(MAX_FILTERS) +
                     WADDR_MAX_W'(c_idx);
  assign sv_addr = cur.sbase + VADDR_MAX_W'(f_idx);
  assign rv_addr = cur.rbase + VADDR_MAX_W'(f_idx);

  always_comb begin
    v_raddr = (step == UPD_WR) ? rv_addr[VAW-1:0] : sv_addr[VAW-1:0];
    unique case (step)
      UPD_BIAS_R: w_raddr = bias_addr[WAW-1:0];
      UPD_VS:     w_raddr = ws_addr[WAW-1:0];
      default:    w_raddr = wr_addr[WAW-1:0];
    endcase
    if (cur.kind == CMD_EDGE) begin
      unique case (step)
        UPD_BIAS_W: wg_addr = bias_addr[WAW-1:0];
        UPD_WS:     wg_addr = ws_addr[WAW-1:0];
        default:    wg_addr = wr_addr[WAW-1:0];
      endcase
      vg_addr = (step == UPD_VS) ? sv_addr[VAW-1:0] : rv_addr[VAW-1:0];
    end else begin
      wg_addr = cur.waddr[WAW-1:0];
      vg_addr = cur.vaddr[VAW-1:0];
    end
  end

  assign f_last = (f_idx + CNT_W'(1)) >= lim.nf;
  assign c_last = (c_idx + CNT_W'(1)) >= lim.nc;
  assign edge_last = c_last && ((step == UPD_VR && f_last) ||
                                (step == UPD_BIAS_R && lim.nf == '0));
  assign clr_last = (clr_addr == CAW'(CLR_DEPTH - 1));

  always_comb begin
    unique case (step)
      UPD_BIAS_W:     operand = cur.data;
      UPD_WS, UPD_WR: operand = v_q;
      default:        operand = w_q;
    endcase
  end

  assign full_prod = cur.grad * operand;
  assign wg_sum = sat_add(wg_q, prod);
  assign vg_sum = sat_add(vg_q, prod);
  assign res_sum = sat_add(res_acc, prod);

  // Memories.
  always_ff @(posedge clk) begin
    if (v_we) begin
      vmem[cur.vaddr[VAW-1:0]] <= cur.data;
    end
    v_q <= vmem[v_raddr];
  end

  always_ff @(posedge clk) begin
    if (w_we) begin
      wmem[cur.waddr[WAW-1:0]] <= cur.data;
    end
    w_q <= wmem[w_raddr];
  end

  always_ff @(posedge clk) begin
    if (wg_we) begin
      wgmem[(state == ST_CLEAR) ? clr_addr[WAW-1:0] : wg_addr] <= wg_wdata;
    end
    wg_q <= wgmem[wg_addr];
  end

  always_ff @(posedge clk) begin
    if (vg_we) begin
      vgmem[(state == ST_CLEAR) ? clr_addr[VAW-1:0] : vg_addr] <= vg_wdata;
    end
    vg_q <= vgmem[vg_addr];
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  state_next = clr_last ? ST_IDLE : ST_CLEAR;
      ST_IDLE:   state_next = q_empty ? ST_IDLE : ST_DECODE;
      ST_DECODE: begin
        unique case (cur.kind)
          CMD_CLEAR:              state_next = ST_CLEAR;
          CMD_READ_W, CMD_READ_V: state_next = ST_READ;
          CMD_EDGE:               state_next = (lim.nc == '0) ? ST_IDLE : ST_E_ADDR;
          default:                state_next = ST_IDLE;
        endcase
      end
      ST_READ:   state_next = ST_IDLE;
      ST_E_ADDR: state_next = ST_E_MUL;
      ST_E_MUL:  state_next = ST_E_ACC;
      ST_E_ACC:  state_next = edge_last ? ST_IDLE : ST_E_ADDR;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    pop = 1'b0;
    v_we = 1'b0;
    w_we = 1'b0;
    wg_we = 1'b0;
    vg_we = 1'b0;
    wg_wdata = wg_sum;
    vg_wdata = vg_sum;
    emit = 1'b0;
    emit_res.result_value = '0;
    emit_res.status = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        wg_we = 32'(clr_addr) < WDEPTH;
        vg_we = 32'(clr_addr) < VDEPTH;
        wg_wdata = '0;
        vg_wdata = '0;
        emit = clr_last && clr_reply;
      end
      ST_IDLE: begin
        pop = !q_empty;
      end
      ST_DECODE: begin
        unique case (cur.kind)
          CMD_LOAD_V: begin
            v_we = 1'b1;
            emit = 1'b1;
          end
          CMD_LOAD_W: begin
            w_we = 1'b1;
            emit = 1'b1;
          end
          CMD_FLAG: begin
            emit = 1'b1;
            emit_res.status = 1'b1;
          end
          CMD_EDGE: begin
            emit = (lim.nc == '0);
          end
          default: begin
            emit = 1'b0;
          end
        endcase
      end
      ST_READ: begin
        emit = 1'b1;
        emit_res.result_value = (cur.kind == CMD_READ_W) ? wg_q : vg_q;
      end
      ST_E_ACC: begin
        unique case (step)
          UPD_BIAS_W, UPD_WS, UPD_WR: wg_we = 1'b1;
          UPD_VS, UPD_VR:             vg_we = 1'b1;
          default:                    wg_we = 1'b0;
        endcase
        emit = edge_last;
        emit_res.result_value = (step == UPD_BIAS_R) ? res_sum : res_acc;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  assign init_busy = (state == ST_CLEAR) && !clr_reply;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_addr <= '0;
      clr_reply <= 1'b0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= emit;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + CAW'(1);
        if (clr_last) begin
          clr_reply <= 1'b0;
        end
      end else if (state == ST_DECODE && cur.kind == CMD_CLEAR) begin
        clr_addr <= '0;
        clr_reply <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result <= emit_res;
    end
    if (pop) begin
      cur <= head;
    end
    if (state == ST_DECODE) begin
      step <= UPD_BIAS_W;
      f_idx <= '0;
      c_idx <= '0;
      res_acc <= '0;
    end
    if (state == ST_E_MUL) begin
      prod <= full_prod[2*Q_W-1:16];
    end
    if (state == ST_E_ACC) begin
      unique case (step)
        UPD_BIAS_W: step <= UPD_BIAS_R;
        UPD_BIAS_R: begin
          res_acc <= res_sum;
          f_idx <= '0;
          if (lim.nf != '0) begin
            step <= UPD_WS;
          end else begin
            step <= UPD_BIAS_W;
            c_idx <= c_idx + CNT_W'(1);
          end
        end
        UPD_WS: step <= UPD_WR;
        UPD_WR: step <= UPD_VS;
        UPD_VS: step <= UPD_VR;
        UPD_VR: begin
          if (!f_last) begin
            f_idx <= f_idx + CNT_W'(1);
            step <= UPD_WS;
          end else begin
            f_idx <= '0;
            c_idx <= c_idx + CNT_W'(1);
            step <= UPD_BIAS_W;
          end
        end
        default: step <= UPD_BIAS_W;
      endcase
    end
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) pop |-> !q_empty)
    else $error("command taken from an empty queue");

  a_idle_no_grad_write: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !wg_we && !vg_we)
    else $error("gradient store written while idle");

  a_edge_reply: assert property (@(posedge clk) disable iff (rst)
    (state == ST_E_ACC && edge_last) |=> done)
    else $error("edge finished without a result");

  a_feature_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_E_ACC && (step == UPD_WS || step == UPD_WR || step == UPD_VS ||
     step == UPD_VR)) |-> f_idx < lim.nf)
    else $error("feature counter beyond feature count");

  a_init_blocks_pop: assert property (@(posedge clk) disable iff (rst)
    init_busy |-> !pop)
    else $error("command taken during the clearing pass after reset");

endmodule

// ----- hdl/graph_edge_conv_gradient_top.sv -----
// Top level of the edge graph convolution gradient block: configuration and wiring.
// A request is taken when start is high and busy is low; every request gives exactly one
// result, shown for one cycle with done high, which the receiver must take then. Requests
// pass through a two-entry queue to a single execution sequencer, which handles one at a
// time. An edge runs its updates through read, multiply and accumulate steps on the one
// shared multiplier and store ports. A clear request sweeps both gradient stores one address
// a cycle, over every address of the deeper of the two stores (MAX_BATCH * MAX_NODES *
// MAX_FEATURES, 16384 entries by default). The same sweep runs after reset, with busy high
// until it ends.
module graph_edge_conv_gradient_top import gecg_pkg::*; #(
  parameter int MAX_FEATURES = 16,
  parameter int MAX_FILTERS = 16,
  parameter int MAX_NODES = 256,
  parameter int MAX_BATCH = 4
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  request_t request,
  output logic     done,
  output result_t  result,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_data
);

  logic [4:0] feature_count;
  logic [4:0] filter_count;
  logic [8:0] node_count;
  limits_t lim;
  cmd_t front_cmd;
  cmd_t head;
  logic q_empty;
  logic q_full;
  logic pop;
  logic init_busy;
  logic push;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      feature_count <= 5'd16;
      filter_count <= 5'd16;
      node_count <= 9'd256;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FEATURE_COUNT: feature_count <= cfg_data[4:0];
        CFG_FILTER_COUNT:  filter_count <= cfg_data[4:0];
        CFG_NODE_COUNT:    node_count <= cfg_data;
        default:           node_count <= node_count;
      endcase
    end
  end

  always_comb begin
    lim.nf = (CNT_W'(feature_count) < CNT_W'(MAX_FEATURES)) ?
             CNT_W'(feature_count) : CNT_W'(MAX_FEATURES);
    lim.nc = (CNT_W'(filter_count) < CNT_W'(MAX_FILTERS)) ?
             CNT_W'(filter_count) : CNT_W'(MAX_FILTERS);
    lim.nn = (NODE_CNT_W'(node_count) < NODE_CNT_W'(MAX_NODES)) ?
             NODE_CNT_W'(node_count) : NODE_CNT_W'(MAX_NODES);
  end

  assign busy = q_full || init_busy;
  assign push = start && !busy;

  gecg_front #(
    .MAX_FEATURES(MAX_FEATURES),
    .MAX_FILTERS(MAX_FILTERS),
    .MAX_NODES(MAX_NODES),
    .MAX_BATCH(MAX_BATCH)
  ) u_front (
    .request(request),
    .lim(lim),
    .cmd(front_cmd)
  );

  gecg_fifo u_fifo (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_data(front_cmd),
    .pop(pop),
    .pop_data(head),
    .empty(q_empty),
    .full(q_full)
  );

  gecg_back #(
    .MAX_FEATURES(MAX_FEATURES),
    .MAX_FILTERS(MAX_FILTERS),
    .MAX_NODES(MAX_NODES),
    .MAX_BATCH(MAX_BATCH)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .lim(lim),
    .q_empty(q_empty),
    .head(head),
    .pop(pop),
    .init_busy(init_busy),
    .done(done),
    .result(result)
  );

endmodule

// ----- tb/sv/tb_graph_edge_conv_gradient_top.sv -----
// Self-checking testbench of the edge graph convolution gradient block.
module tb_graph_edge_conv_gradient_top;
  import gecg_pkg::*;

  localparam int N_FEAT = 16;
  localparam int N_FILT = 16;
  localparam int N_NODE = 256;
  localparam int V_DEPTH = 4 * N_NODE * N_FEAT;
  localparam int W_DEPTH = (2 * N_FEAT + 1) * N_FILT;
  localparam longint ACC_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint ACC_LO = -ACC_HI - 1;
  localparam logic [2:0] OP_RESERVED_A = 3'd6;
  localparam logic [2:0] OP_RESERVED_B = 3'd7;
  localparam int STALL_LIMIT = 60000;

  typedef struct {
    request_t req;
    bit       typed;
    result_t  res;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  request_t   request = '0;
  logic       done;
  result_t    result;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [8:0] cfg_data = '0;

  // Predictor state.
  int     vert_mem [V_DEPTH];
  int     wt_mem [W_DEPTH];
  longint wt_grad [W_DEPTH];
  longint vert_grad [V_DEPTH];
  int     cur_nf = 16;
  int     cur_nc = 16;
  int     cur_nn = 256;

  result_t   pending_results[$];
  stim_row_t dir_rows[$];
  int        err_count = 0;
  int        sent_count = 0;
  int        edge_count = 0;
  int        checked_count = 0;
  int        stall_cycles = 0;
  int        node_set[5] = '{0, 1, 2, 3, 255};

  always #6 clk = ~clk;

  graph_edge_conv_gradient_top i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  function automatic longint fx_mul(longint a, longint b);
    longint p;
    p = a * b;
    return p >>> 16;
  endfunction

  function automatic longint acc_add(longint a, longint b);
    longint s;
    s = a + b;
    if (s > ACC_HI) return ACC_HI;
    if (s < ACC_LO) return ACC_LO;
    return s;
  endfunction

  // Applies one request to the predictor state and returns the result it causes.
  function automatic result_t compute_response(request_t r);
    result_t o;
    longint  res;
    longint  g;
    longint  val;
    int      b;
    int      na;
    int      nb;
    int      fi;
    int      ci;
    int      vidx;
    int      widx;
    int      sb;
    int      rb;
    int      bias;
    int      ws;
    int      wr;
    bit      vert_ok;
    bit      w_ok;
    res = 0;
    o.status = 1'b0;
    b = r.batch_index;
    na = r.node_a;
    nb = r.node_b;
    fi = r.feature_index;
    ci = r.filter_index;
    val = longint'(r.data_value);
    g = longint'(r.upstream_gradient);
    vert_ok = (na < cur_nn) && (fi < cur_nf);
    w_ok = (fi <= 2 * cur_nf) && (ci < cur_nc);
    vidx = (b * N_NODE + na) * N_FEAT + fi;
    widx = fi * N_FILT + ci;
    case (r.opcode)
      OP_LOAD_VERTEX: begin
        if (vert_ok) vert_mem[vidx] = r.data_value;
        else o.status = 1'b1;
      end
      OP_LOAD_WEIGHT: begin
        if (w_ok) wt_mem[widx] = r.data_value;
        else o.status = 1'b1;
      end
      OP_EDGE: begin
        if (na < cur_nn && nb < cur_nn) begin
          sb = (b * N_NODE + na) * N_FEAT;
          rb = (b * N_NODE + nb) * N_FEAT;
          bias = 2 * cur_nf * N_FILT;
          for (int c = 0; c < cur_nc; c++) begin
            wt_grad[bias + c] = acc_add(wt_grad[bias + c], fx_mul(g, val));
            res = acc_add(res, fx_mul(g, longint'(wt_mem[bias + c])));
            for (int f = 0; f < cur_nf; f++) begin
              ws = f * N_FILT + c;
              wr = (cur_nf + f) * N_FILT + c;
              wt_grad[ws] = acc_add(wt_grad[ws], fx_mul(g, longint'(vert_mem[sb + f])));
              wt_grad[wr] = acc_add(wt_grad[wr], fx_mul(g, longint'(vert_mem[rb + f])));
              vert_grad[sb + f] = acc_add(vert_grad[sb + f], fx_mul(g, longint'(wt_mem[ws])));
              vert_grad[rb + f] = acc_add(vert_grad[rb + f], fx_mul(g, longint'(wt_mem[wr])));
            end
          end
        end else begin
          o.status = 1'b1;
        end
      end
      OP_READ_WGRAD: begin
        if (w_ok) res = wt_grad[widx];
        else o.status = 1'b1;
      end
      OP_READ_VGRAD: begin
        if (vert_ok) res = vert_grad[vidx];
        else o.status = 1'b1;
      end
      OP_CLEAR: begin
        foreach (wt_grad[i]) wt_grad[i] = 0;
        foreach (vert_grad[i]) vert_grad[i] = 0;
      end
      default: o.status = 1'b1;
    endcase
    o.result_value = res[47:0];
    return o;
  endfunction

  function automatic request_t mk_req(logic [2:0] op, int b, int na, int nb, int fi, int ci,
                                      logic [31:0] d, logic [31:0] g);
    request_t r;
    r.opcode = op;
    r.batch_index = 2'(b);
    r.node_a = 8'(na);
    r.node_b = 8'(nb);
    r.feature_index = 6'(fi);
    r.filter_index = 4'(ci);
    r.data_value = d;
    r.upstream_gradient = g;
    return r;
  endfunction

  function automatic logic [31:0] rand_q();
    logic [31:0] v;
    if ($urandom_range(0, 3) == 0) begin
      v = $urandom;
    end else begin
      v = $urandom_range(0, 32'h0003_FFFF);
      if ($urandom_range(0, 1)) v = -v;
    end
    return v;
  endfunction

  function automatic request_t rand_request();
    request_t    r;
    logic [95:0] raw;
    int          pick;
    raw = {$urandom, $urandom, $urandom};
    r = raw[$bits(request_t)-1:0];
    r.data_value = rand_q();
    r.upstream_gradient = rand_q();
    if ($urandom_range(0, 4) != 0) r.feature_index = 6'($urandom_range(0, 2 * cur_nf + 1));
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      r.opcode = OP_EDGE;
      // Sender and receiver come from the vertices whose features were all loaded.
      r.node_a = 8'(node_set[$urandom_range(0, 4)]);
      r.node_b = 8'(node_set[$urandom_range(0, 4)]);
    end else if (pick < 50) begin
      r.opcode = OP_READ_WGRAD;
    end else if (pick < 65) begin
      r.opcode = OP_READ_VGRAD;
      if ($urandom_range(0, 1)) r.node_a = 8'(node_set[$urandom_range(0, 4)]);
    end else if (pick < 77) begin
      r.opcode = OP_LOAD_VERTEX;
    end else if (pick < 89) begin
      r.opcode = OP_LOAD_WEIGHT;
    end else if (pick < 97) begin
      r.opcode = ($urandom_range(0, 199) == 0) ? OP_CLEAR : OP_READ_WGRAD;
    end else begin
      r.opcode = $urandom_range(0, 1) ? OP_RESERVED_A : OP_RESERVED_B;
    end
    return r;
  endfunction

  task automatic send(request_t r, int idle_pct, bit typed, result_t typed_res);
    result_t p;
    @(negedge clk);
    while ($urandom_range(1, 100) <= idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    request = r;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    p = compute_response(r);
    pending_results.push_back(typed ? typed_res : p);
    sent_count++;
    if (r.opcode == OP_EDGE) edge_count++;
  endtask

  task automatic write_cfg(logic [1:0] idx, int value);
    @(negedge clk);
    start = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    // Let the sequencer settle back to idle before touching the limits.
    repeat (10) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = 9'(value);
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    @(negedge clk);
    cfg_valid = 1'b0;
    case (idx)
      CFG_FEATURE_COUNT: cur_nf = value;
      CFG_FILTER_COUNT: cur_nc = value;
      default: cur_nn = value;
    endcase
  endtask

  task automatic random_phase(int count, int idle_pct);
    for (int i = 0; i < count; i++) send(rand_request(), idle_pct, 1'b0, '0);
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result value=%0d status=%0b", $time,
                 result.result_value, result.status);
        err_count++;
      end else begin
        if (result.result_value !== pending_results[0].result_value ||
            result.status !== pending_results[0].status) begin
          $display("%0t: mismatch expected value=%0d status=%0b, actual value=%0d status=%0b",
                   $time, pending_results[0].result_value, pending_results[0].status,
                   result.result_value, result.status);
          err_count++;
        end
        void'(pending_results.pop_front());
        checked_count++;
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || done || (cfg_valid && cfg_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic stim_row_t row(request_t r, bit typed, logic [47:0] v, logic s);
    stim_row_t x;
    x.req = r;
    x.typed = typed;
    x.res.result_value = v;
    x.res.status = s;
    return x;
  endfunction

  initial begin
    foreach (vert_mem[i]) vert_mem[i] = 0;
    foreach (wt_mem[i]) wt_mem[i] = 0;
    foreach (wt_grad[i]) wt_grad[i] = 0;
    foreach (vert_grad[i]) vert_grad[i] = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Fill every weight and the features of the vertices that edges will use.
    for (int w = 0; w < W_DEPTH; w++)
      send(mk_req(OP_LOAD_WEIGHT, 0, 0, 0, w / N_FILT, w % N_FILT, rand_q(), 0), 0, 1'b0, '0);
    for (int b = 0; b < 4; b++)
      foreach (node_set[n])
        for (int f = 0; f < N_FEAT; f++)
          send(mk_req(OP_LOAD_VERTEX, b, node_set[n], 0, f, 0, rand_q(), 0), 0, 1'b0, '0);

    dir_rows.push_back(row(mk_req(OP_READ_WGRAD, 0, 0, 0, 0, 0, 0, 0), 1, 0, 0));
    dir_rows.push_back(row(mk_req(OP_READ_VGRAD, 3, 255, 0, 15, 0, 0, 0), 1, 0, 0));
    dir_rows.push_back(row(mk_req(OP_LOAD_VERTEX, 3, 255, 255, 15, 15, 32'h7FFF_FFFF,
                                  32'hFFFF_FFFF), 1, 0, 0));
    dir_rows.push_back(row(mk_req(OP_LOAD_WEIGHT, 0, 0, 0, 32, 15, 32'h8000_0000, 0),
                           1, 0, 0));
    dir_rows.push_back(row(mk_req(OP_LOAD_VERTEX, 0, 0, 0, 16, 0, 1, 0), 1, 0, 1));
    dir_rows.push_back(row(mk_req(OP_LOAD_WEIGHT, 0, 0, 0, 33, 0, 1, 0), 1, 0, 1));
    dir_rows.push_back(row(mk_req(OP_READ_WGRAD, 0, 0, 0, 63, 0, 0, 0), 1, 0, 1));
    dir_rows.push_back(row(mk_req(OP_READ_VGRAD, 0, 0, 0, 40, 0, 0, 0), 1, 0, 1));
    dir_rows.push_back(row(mk_req(OP_RESERVED_A, 0, 0, 0, 0, 0, 0, 0), 1, 0, 1));
    dir_rows.push_back(row(mk_req(OP_RESERVED_B, 3, 255, 255, 63, 15, 32'hFFFF_FFFF,
                                  32'hFFFF_FFFF), 1, 0, 1));
    dir_rows.push_back(row(mk_req(OP_EDGE, 0, 0, 255, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000),
                           0, 0, 0));
    dir_rows.push_back(row(mk_req(OP_EDGE, 2, 3, 3, 0, 0, 32'h0001_8000, 32'hFFFF_0000),
                           0, 0, 0));
    dir_rows.push_back(row(mk_req(OP_EDGE, 3, 255, 0, 0, 0, 32'h8000_0000, 32'h8000_0000),
                           0, 0, 0));
    dir_rows.push_back(row(mk_req(OP_EDGE, 1, 1, 2, 0, 0, 32'h0002_0000, 0), 0, 0, 0));
    dir_rows.push_back(row(mk_req(OP_READ_WGRAD, 0, 0, 0, 32, 0, 0, 0), 0, 0, 0));
    dir_rows.push_back(row(mk_req(OP_READ_VGRAD, 2, 3, 0, 0, 0, 0, 0), 0, 0, 0));
    dir_rows.push_back(row(mk_req(OP_READ_VGRAD, 3, 255, 0, 15, 0, 0, 0), 0, 0, 0));
    dir_rows.push_back(row(mk_req(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0), 1, 0, 0));
    dir_rows.push_back(row(mk_req(OP_READ_WGRAD, 0, 0, 0, 32, 0, 0, 0), 1, 0, 0));
    dir_rows.push_back(row(mk_req(OP_READ_VGRAD, 3, 255, 0, 15, 0, 0, 0), 1, 0, 0));
    foreach (dir_rows[i]) send(dir_rows[i].req, 0, dir_rows[i].typed, dir_rows[i].res);

    // Small sizes keep edges short; the sender idles a quarter of the time.
    write_cfg(CFG_FEATURE_COUNT, 3);
    write_cfg(CFG_FILTER_COUNT, 2);
    write_cfg(CFG_NODE_COUNT, 200);
    random_phase(60, 26);

    // Limits of one: only vertex 0 is in range, so most edges are flagged.
    write_cfg(CFG_FEATURE_COUNT, 1);
    write_cfg(CFG_FILTER_COUNT, 1);
    write_cfg(CFG_NODE_COUNT, 1);
    random_phase(40, 67);

    write_cfg(CFG_NODE_COUNT, 256);
    write_cfg(CFG_FILTER_COUNT, 4);
    random_phase(30, 0);

    // A few full-size edges at the largest limits.
    write_cfg(CFG_FEATURE_COUNT, 16);
    write_cfg(CFG_FILTER_COUNT, 16);
    random_phase(20, 0);

    @(negedge clk);
    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Sent %0d requests (%0d edges), checked %0d results over four limit settings.",
             sent_count, edge_count, checked_count);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
